@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this project.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define CTT_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define CTT_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/ctt_pkg.sv @@
// Shared constants and types of the circle-through-three-points unit.
// No dependencies.
package ctt_pkg;

    localparam int COORD_WIDTH_DEF = 12;
    localparam int CENTER_W        = 24;
    localparam int RADIUS_W        = 25;
    localparam int M_DATA_W        = ((2 * CENTER_W + RADIUS_W + 7) / 8) * 8;
    localparam int M_USER_W        = 2;

    // m_tuser bit positions
    localparam int USER_COLLINEAR  = 0;
    localparam int USER_SATURATED  = 1;

    localparam logic [CENTER_W-1:0] CENTER_MAX = {1'b0, {(CENTER_W-1){1'b1}}};
    localparam logic [CENTER_W-1:0] CENTER_MIN = {1'b1, {(CENTER_W-1){1'b0}}};

    // Payload that rides along the square-root chain.
    typedef struct packed {
        logic [CENTER_W-1:0] cx;
        logic [CENTER_W-1:0] cy;
        logic                sat;
        logic                col;
    } ctr_side_t;

endpackage

@@ hw/rtl/ctt_div_cell.sv @@
// One restoring-division cell: one quotient bit for both center coordinates.
// Standalone; chained by the top level.
module ctt_div_cell #(
    parameter int DMW    = 27,
    parameter int NMW    = 37,
    parameter int SIDE_W = 27
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  up_ready,
    output logic                  out_valid,
    input  logic                  down_ready,
    input  logic [DMW-1:0]        in_den,
    input  logic [DMW+NMW-1:0]    in_wx,
    input  logic [DMW+NMW-1:0]    in_wy,
    input  logic [SIDE_W-1:0]     in_side,
    output logic [DMW-1:0]        out_den,
    output logic [DMW+NMW-1:0]    out_wx,
    output logic [DMW+NMW-1:0]    out_wy,
    output logic [SIDE_W-1:0]     out_side
);

    // {remainder, dividend} shifts left; quotient bits enter at the bottom.
    function automatic logic [DMW+NMW-1:0] div_step(input logic [DMW+NMW-1:0] w,
                                                    input logic [DMW-1:0] d);
        logic [DMW:0] hi;
        logic [DMW:0] diff;
        hi   = w[DMW+NMW-1 -: DMW+1];
        diff = hi - {1'b0, d};
        if (hi >= {1'b0, d}) begin
            return {diff[DMW-1:0], w[NMW-2:0], 1'b1};
        end
        return {hi[DMW-1:0], w[NMW-2:0], 1'b0};
    endfunction

    logic                 valid_reg;
    logic [DMW-1:0]       den_reg;
    logic [DMW+NMW-1:0]   wx_reg;
    logic [DMW+NMW-1:0]   wy_reg;
    logic [SIDE_W-1:0]    side_reg;

    assign up_ready  = !valid_reg || down_ready;
    assign out_valid = valid_reg;
    assign out_den   = den_reg;
    assign out_wx    = wx_reg;
    assign out_wy    = wy_reg;
    assign out_side  = side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_ready) begin
            den_reg  <= in_den;
            wx_reg   <= div_step(in_wx, in_den);
            wy_reg   <= div_step(in_wy, in_den);
            side_reg <= in_side;
        end
    end

endmodule

@@ hw/rtl/ctt_sqrt_cell.sv @@
// One digit-recurrence square-root cell: one root bit per cell.
// Standalone; chained by the top level.
module ctt_sqrt_cell #(
    parameter int RW     = 25,
    parameter int SIDE_W = 50
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               up_ready,
    output logic               out_valid,
    input  logic               down_ready,
    input  logic [2*RW-1:0]    in_n,
    input  logic [RW:0]        in_rem,
    input  logic [RW-1:0]      in_root,
    input  logic [SIDE_W-1:0]  in_side,
    output logic [2*RW-1:0]    out_n,
    output logic [RW:0]        out_rem,
    output logic [RW-1:0]      out_root,
    output logic [SIDE_W-1:0]  out_side
);

    logic              valid_reg;
    logic [2*RW-1:0]   n_reg;
    logic [RW:0]       rem_reg;
    logic [RW-1:0]     root_reg;
    logic [SIDE_W-1:0] side_reg;

    logic [RW+2:0]     hi;
    logic [RW+2:0]     trial;
    logic [RW+2:0]     diff;
    logic              ge;
    logic [RW:0]       rem_next;
    logic [RW-1:0]     root_next;

    // bring down two radicand bits, try subtracting 4*root+1
    always_comb begin
        hi        = {in_rem, in_n[2*RW-1 -: 2]};
        trial     = {1'b0, in_root, 2'b01};
        diff      = hi - trial;
        ge        = (hi >= trial);
        rem_next  = ge ? diff[RW:0] : hi[RW:0];
        root_next = {in_root[RW-2:0], ge};
    end

    assign up_ready  = !valid_reg || down_ready;
    assign out_valid = valid_reg;
    assign out_n     = n_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_side  = side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_ready) begin
            n_reg    <= {in_n[2*RW-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= in_side;
        end
    end

endmodule

@@ hw/rtl/circle_through_three_points_unit.sv @@
// Top level of the circle-through-three-points unit.
// Depends on ctt_pkg, ctt_div_cell and ctt_sqrt_cell.
//
// Takes three signed points per input transaction and returns the center
// (each coordinate the truncated quotient of Cramer's rule on the two
// perpendicular bisectors, clipped to 24-bit signed) and the floor square
// root of the squared distance from that center to the first point. Points
// on one line give collinear=1 with all other fields zero; a clipped center
// gives saturated=1. The unit takes one transaction per cycle unless
// m_tready holds it back, and returns results in order. Four front stages
// form the bisector terms, the determinant and numerator products and their
// magnitudes; a chain of 3*COORD_WIDTH+1 division cells yields one quotient
// bit each for both coordinates; three stages clip the center, square and
// sum the offsets; a chain of 25 square-root cells yields one radius bit
// each. Every stage holds its own valid bit and moves when the stage after
// it is empty or moving, so bubbles collapse and input is taken while a
// result waits.
module circle_through_three_points_unit #(
    parameter int COORD_WIDTH = ctt_pkg::COORD_WIDTH_DEF,
    localparam int S_DATA_W = ((6 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // first_x, first_y, second_x, second_y, third_x, third_y (low bits up)
    input  logic [S_DATA_W-1:0]           s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // center_x[23:0], center_y[47:24], radius[72:48], zero pad
    output logic [ctt_pkg::M_DATA_W-1:0]  m_tdata,
    // collinear[0], saturated[1]
    output logic [ctt_pkg::M_USER_W-1:0]  m_tuser
);
    import ctt_pkg::*;

    localparam int W      = COORD_WIDTH;
    localparam int EW     = W + 2;          // doubled coordinate difference
    localparam int SQW    = 2 * W;          // coordinate square
    localparam int GW     = 2 * W + 1;      // bisector constant term
    localparam int PDW    = 2 * EW;         // determinant products
    localparam int PNW    = GW + EW;        // numerator products
    localparam int NMW    = 3 * W + 1;      // numerator magnitude
    localparam int DMW    = 2 * W + 3;      // determinant magnitude
    localparam int DSIDE  = 3 + 2 * W;      // signs, collinear, first point
    localparam int DXW    = CENTER_W + 1;   // center minus first point
    localparam int NW     = 2 * RADIUS_W;   // squared distance
    localparam int SSIDE  = $bits(ctr_side_t);
    localparam logic [NMW-1:0] CLIM = NMW'(1) << (CENTER_W - 1);

    // ---------------- stage 1: differences and squares ----------------
    logic signed [W-1:0]   x1, y1, x2, y2, x3, y3;
    logic signed [W:0]     d_x21, d_y21, d_x32, d_y32;
    logic signed [EW-1:0]  e1_next, f1_next, a1_next, b1_next;
    logic signed [SQW-1:0] sqx1_next, sqy1_next, sqx2_next, sqy2_next, sqx3_next, sqy3_next;
    logic                  v1_reg, en1;
    logic signed [W-1:0]   x1_1_reg, y1_1_reg;
    logic signed [EW-1:0]  e1_reg, f1_reg, a1_reg, b1_reg;
    logic signed [SQW-1:0] sqx1_reg, sqy1_reg, sqx2_reg, sqy2_reg, sqx3_reg, sqy3_reg;

    assign x1 = s_tdata[0*W +: W];
    assign y1 = s_tdata[1*W +: W];
    assign x2 = s_tdata[2*W +: W];
    assign y2 = s_tdata[3*W +: W];
    assign x3 = s_tdata[4*W +: W];
    assign y3 = s_tdata[5*W +: W];

    always_comb begin
        d_x21     = {x2[W-1], x2} - {x1[W-1], x1};
        d_y21     = {y2[W-1], y2} - {y1[W-1], y1};
        d_x32     = {x3[W-1], x3} - {x2[W-1], x2};
        d_y32     = {y3[W-1], y3} - {y2[W-1], y2};
        e1_next   = {d_x21, 1'b0};
        f1_next   = {d_y21, 1'b0};
        a1_next   = {d_x32, 1'b0};
        b1_next   = {d_y32, 1'b0};
        sqx1_next = x1 * x1;
        sqy1_next = y1 * y1;
        sqx2_next = x2 * x2;
        sqy2_next = y2 * y2;
        sqx3_next = x3 * x3;
        sqy3_next = y3 * y3;
    end

    // ---------------- stage 2: constant terms, determinant products ----
    logic signed [GW-1:0]  g2_next, c2_next;
    logic signed [PDW-1:0] peb2_next, paf2_next;
    logic                  v2_reg, en2;
    logic signed [W-1:0]   x1_2_reg, y1_2_reg;
    logic signed [EW-1:0]  e2_reg, f2_reg, a2_reg, b2_reg;
    logic signed [GW-1:0]  g2_reg, c2_reg;
    logic signed [PDW-1:0] peb2_reg, paf2_reg;

    always_comb begin
        g2_next   = GW'(sqx2_reg) - GW'(sqx1_reg) + GW'(sqy2_reg) - GW'(sqy1_reg);
        c2_next   = GW'(sqx3_reg) - GW'(sqx2_reg) + GW'(sqy3_reg) - GW'(sqy2_reg);
        peb2_next = e1_reg * b1_reg;
        paf2_next = a1_reg * f1_reg;
    end

    // ---------------- stage 3: determinant, numerator products --------
    logic signed [PDW-1:0] det3_next;
    logic signed [PNW-1:0] gb3_next, cf3_next, ag3_next, ce3_next;
    logic                  v3_reg, en3;
    logic signed [W-1:0]   x1_3_reg, y1_3_reg;
    logic signed [PDW-1:0] det3_reg;
    logic signed [PNW-1:0] gb3_reg, cf3_reg, ag3_reg, ce3_reg;

    always_comb begin
        det3_next = peb2_reg - paf2_reg;
        gb3_next  = g2_reg * b2_reg;
        cf3_next  = c2_reg * f2_reg;
        ag3_next  = a2_reg * g2_reg;
        ce3_next  = c2_reg * e2_reg;
    end

    // ---------------- stage 4: signs and magnitudes --------------------
    logic signed [PNW-1:0] numx, numy;
    logic [PNW-1:0]        absx, absy;
    logic [PDW-1:0]        absd;
    logic [NMW-1:0]        magx4_next, magy4_next;
    logic [DMW-1:0]        magd4_next;
    logic [DSIDE-1:0]      side4_next;
    logic                  v4_reg, en4;
    logic [NMW-1:0]        magx4_reg, magy4_reg;
    logic [DMW-1:0]        magd4_reg;
    logic [DSIDE-1:0]      side4_reg;

    always_comb begin
        numx       = gb3_reg - cf3_reg;
        numy       = ag3_reg - ce3_reg;
        absx       = numx[PNW-1] ? -numx : numx;
        absy       = numy[PNW-1] ? -numy : numy;
        absd       = det3_reg[PDW-1] ? -det3_reg : det3_reg;
        magx4_next = absx[NMW-1:0];
        magy4_next = absy[NMW-1:0];
        magd4_next = absd[DMW-1:0];
        // center_y divides by the negated determinant
        side4_next = {numx[PNW-1] ^ det3_reg[PDW-1],
                      numy[PNW-1] ^ ~det3_reg[PDW-1],
                      det3_reg == '0,
                      x1_3_reg, y1_3_reg};
    end

    // ---------------- division chain -----------------------------------
    logic                   dv_valid [0:NMW];
    logic                   dv_ready [0:NMW];
    logic [DMW-1:0]         dv_den   [0:NMW];
    logic [DMW+NMW-1:0]     dv_wx    [0:NMW];
    logic [DMW+NMW-1:0]     dv_wy    [0:NMW];
    logic [DSIDE-1:0]       dv_side  [0:NMW];

    assign dv_valid[0] = v4_reg;
    assign dv_den[0]   = magd4_reg;
    assign dv_wx[0]    = {{DMW{1'b0}}, magx4_reg};
    assign dv_wy[0]    = {{DMW{1'b0}}, magy4_reg};
    assign dv_side[0]  = side4_reg;

    for (genvar i = 0; i < NMW; i++) begin : g_div
        ctt_div_cell #(
            .DMW    (DMW),
            .NMW    (NMW),
            .SIDE_W (DSIDE)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .in_valid   (dv_valid[i]),
            .up_ready   (dv_ready[i]),
            .out_valid  (dv_valid[i+1]),
            .down_ready (dv_ready[i+1]),
            .in_den     (dv_den[i]),
            .in_wx      (dv_wx[i]),
            .in_wy      (dv_wy[i]),
            .in_side    (dv_side[i]),
            .out_den    (dv_den[i+1]),
            .out_wx     (dv_wx[i+1]),
            .out_wy     (dv_wy[i+1]),
            .out_side   (dv_side[i+1])
        );
    end

    // ---------------- stage 5: clip center, offsets to first point -----
    logic [NMW-1:0]          qx, qy;
    logic                    sgx, sgy, satx, saty;
    logic signed [W-1:0]     px1, py1;
    logic [CENTER_W-1:0]     cx5, cy5;
    ctr_side_t               side5_next;
    logic signed [DXW-1:0]   dx5_next, dy5_next;
    logic                    v5_reg, en5;
    ctr_side_t               side5_reg;
    logic signed [DXW-1:0]   dx5_reg, dy5_reg;

    always_comb begin
        qx   = dv_wx[NMW][NMW-1:0];
        qy   = dv_wy[NMW][NMW-1:0];
        sgx  = dv_side[NMW][2*W+2];
        sgy  = dv_side[NMW][2*W+1];
        px1  = dv_side[NMW][2*W-1:W];
        py1  = dv_side[NMW][W-1:0];
        // positive limit is 2^23-1, negative limit magnitude 2^23
        satx = sgx ? (qx > CLIM) : (qx >= CLIM);
        saty = sgy ? (qy > CLIM) : (qy >= CLIM);
        if (satx) begin
            cx5 = sgx ? CENTER_MIN : CENTER_MAX;
        end else begin
            cx5 = sgx ? -qx[CENTER_W-1:0] : qx[CENTER_W-1:0];
        end
        if (saty) begin
            cy5 = sgy ? CENTER_MIN : CENTER_MAX;
        end else begin
            cy5 = sgy ? -qy[CENTER_W-1:0] : qy[CENTER_W-1:0];
        end
        side5_next.cx  = cx5;
        side5_next.cy  = cy5;
        side5_next.sat = satx | saty;
        side5_next.col = dv_side[NMW][2*W];
        dx5_next = {cx5[CENTER_W-1], cx5} - {{(DXW-W){px1[W-1]}}, px1};
        dy5_next = {cy5[CENTER_W-1], cy5} - {{(DXW-W){py1[W-1]}}, py1};
    end

    // ---------------- stage 6: squares of offsets ----------------------
    logic signed [2*DXW-1:0] dxx6_next, dyy6_next;
    logic                    v6_reg, en6;
    ctr_side_t               side6_reg;
    logic signed [2*DXW-1:0] dxx6_reg, dyy6_reg;

    always_comb begin
        dxx6_next = dx5_reg * dx5_reg;
        dyy6_next = dy5_reg * dy5_reg;
    end

    // ---------------- stage 7: squared distance ------------------------
    logic [NW-1:0]           n7_next;
    logic                    v7_reg, en7;
    ctr_side_t               side7_reg;
    logic [NW-1:0]           n7_reg;

    assign n7_next = NW'(dxx6_reg) + NW'(dyy6_reg);

    // ---------------- square-root chain --------------------------------
    logic                   sq_valid [0:RADIUS_W];
    logic                   sq_ready [0:RADIUS_W];
    logic [NW-1:0]          sq_n     [0:RADIUS_W];
    logic [RADIUS_W:0]      sq_rem   [0:RADIUS_W];
    logic [RADIUS_W-1:0]    sq_root  [0:RADIUS_W];
    logic [SSIDE-1:0]       sq_side  [0:RADIUS_W];

    assign sq_valid[0] = v7_reg;
    assign sq_n[0]     = n7_reg;
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;
    assign sq_side[0]  = side7_reg;

    for (genvar k = 0; k < RADIUS_W; k++) begin : g_sqrt
        ctt_sqrt_cell #(
            .RW     (RADIUS_W),
            .SIDE_W (SSIDE)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .in_valid   (sq_valid[k]),
            .up_ready   (sq_ready[k]),
            .out_valid  (sq_valid[k+1]),
            .down_ready (sq_ready[k+1]),
            .in_n       (sq_n[k]),
            .in_rem     (sq_rem[k]),
            .in_root    (sq_root[k]),
            .in_side    (sq_side[k]),
            .out_n      (sq_n[k+1]),
            .out_rem    (sq_rem[k+1]),
            .out_root   (sq_root[k+1]),
            .out_side   (sq_side[k+1])
        );
    end

    // ---------------- stall chain ---------------------------------------
    // a stage loads when it is empty or its successor loads this cycle
    assign sq_ready[RADIUS_W] = m_tready;
    assign en7      = !v7_reg || sq_ready[0];
    assign en6      = !v6_reg || en7;
    assign en5      = !v5_reg || en6;
    assign dv_ready[NMW] = en5;
    assign en4      = !v4_reg || dv_ready[0];
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= s_tvalid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
            if (en3) begin
                v3_reg <= v2_reg;
            end
            if (en4) begin
                v4_reg <= v3_reg;
            end
            if (en5) begin
                v5_reg <= dv_valid[NMW];
            end
            if (en6) begin
                v6_reg <= v5_reg;
            end
            if (en7) begin
                v7_reg <= v6_reg;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (en1) begin
            x1_1_reg <= x1;
            y1_1_reg <= y1;
            e1_reg   <= e1_next;
            f1_reg   <= f1_next;
            a1_reg   <= a1_next;
            b1_reg   <= b1_next;
            sqx1_reg <= sqx1_next;
            sqy1_reg <= sqy1_next;
            sqx2_reg <= sqx2_next;
            sqy2_reg <= sqy2_next;
            sqx3_reg <= sqx3_next;
            sqy3_reg <= sqy3_next;
        end
        if (en2) begin
            x1_2_reg <= x1_1_reg;
            y1_2_reg <= y1_1_reg;
            e2_reg   <= e1_reg;
            f2_reg   <= f1_reg;
            a2_reg   <= a1_reg;
            b2_reg   <= b1_reg;
            g2_reg   <= g2_next;
            c2_reg   <= c2_next;
            peb2_reg <= peb2_next;
            paf2_reg <= paf2_next;
        end
        if (en3) begin
            x1_3_reg <= x1_2_reg;
            y1_3_reg <= y1_2_reg;
            det3_reg <= det3_next;
            gb3_reg  <= gb3_next;
            cf3_reg  <= cf3_next;
            ag3_reg  <= ag3_next;
            ce3_reg  <= ce3_next;
        end
        if (en4) begin
            magx4_reg <= magx4_next;
            magy4_reg <= magy4_next;
            magd4_reg <= magd4_next;
            side4_reg <= side4_next;
        end
        if (en5) begin
            side5_reg <= side5_next;
            dx5_reg   <= dx5_next;
            dy5_reg   <= dy5_next;
        end
        if (en6) begin
            side6_reg <= side5_reg;
            dxx6_reg  <= dxx6_next;
            dyy6_reg  <= dyy6_next;
        end
        if (en7) begin
            side7_reg <= side6_reg;
            n7_reg    <= n7_next;
        end
    end

    // ---------------- result --------------------------------------------
    ctr_side_t res_side;

    assign res_side = sq_side[RADIUS_W];
    assign m_tvalid = sq_valid[RADIUS_W];

    // collinear points: everything but the flag reads zero
    always_comb begin
        if (res_side.col) begin
            m_tdata = '0;
        end else begin
            m_tdata = M_DATA_W'({sq_root[RADIUS_W], res_side.cy, res_side.cx});
        end
        m_tuser                 = '0;
        m_tuser[USER_COLLINEAR] = res_side.col;
        m_tuser[USER_SATURATED] = res_side.sat & ~res_side.col;
    end

endmodule

@@ hw/rtl/ctt_chk.sv @@
// Port-level checker for the circle-through-three-points unit, bound to the top.
// Depends on ctt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ctt_chk (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ctt_pkg::M_DATA_W-1:0]  m_tdata,
    input logic [ctt_pkg::M_USER_W-1:0]  m_tuser
);
    import ctt_pkg::*;

    logic [CENTER_W-1:0] cx;
    logic [CENTER_W-1:0] cy;
    logic                col_seen;
    logic                col_clean;
    logic                sat_seen;
    logic                on_limit;
    logic                stalled;

    assign cx        = m_tdata[CENTER_W-1:0];
    assign cy        = m_tdata[2*CENTER_W-1:CENTER_W];
    assign col_seen  = m_tvalid && m_tuser[USER_COLLINEAR];
    assign col_clean = (m_tdata == '0) && !m_tuser[USER_SATURATED];
    assign sat_seen  = m_tvalid && m_tuser[USER_SATURATED];
    assign on_limit  = (cx == CENTER_MAX) || (cx == CENTER_MIN) ||
                       (cy == CENTER_MAX) || (cy == CENTER_MIN);
    assign stalled   = m_tvalid && !m_tready;

    // collinear result carries nothing else
    `CTT_ASSERT_IMP(a_col_zero, aclk, aresetn, col_seen, col_clean)

    // a clipped center sits on a range limit
    `CTT_ASSERT_IMP(a_sat_limit, aclk, aresetn, sat_seen, on_limit)

    // stalled transaction stays offered and unchanged
    `CTT_ASSERT_NXT(a_hold_valid, aclk, aresetn, stalled, m_tvalid)
    `CTT_ASSERT_NXT(a_hold_data, aclk, aresetn, stalled, $stable(m_tdata) && $stable(m_tuser))

endmodule

bind circle_through_three_points_unit ctt_chk u_ctt_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
